// File: rtl/ldpl_pkg.sv
// Package for the LED dim pattern level block: segment types and codes.
package ldpl_pkg;

    localparam int NSEG = 12;

    // Segment kinds
    localparam logic [1:0] SEG_CONST = 2'd0;
    localparam logic [1:0] SEG_UP    = 2'd1;
    localparam logic [1:0] SEG_DOWN  = 2'd2;

    // Pattern codes
    localparam logic [3:0] PAT_COMET     = 4'd0;
    localparam logic [3:0] PAT_RCOMET    = 4'd1;
    localparam logic [3:0] PAT_TWOSIDED  = 4'd2;
    localparam logic [3:0] PAT_BARBELL   = 4'd3;
    localparam logic [3:0] PAT_STOW_HI   = 4'd4;
    localparam logic [3:0] PAT_STOW_LO   = 4'd5;
    localparam logic [3:0] PAT_SLIDE_HI  = 4'd6;
    localparam logic [3:0] PAT_SLIDE_LO  = 4'd7;
    localparam logic [3:0] PAT_BOWTIE    = 4'd8;
    localparam logic [3:0] PAT_RBOWTIE   = 4'd9;
    localparam logic [3:0] PAT_TOWERS    = 4'd10;
    localparam logic [3:0] PAT_SNAKE     = 4'd11;
    localparam logic [3:0] PAT_SNAKE3    = 4'd12;
    localparam logic [3:0] PAT_COMETS3   = 4'd13;
    localparam logic [3:0] PAT_RCOMETS3  = 4'd14;
    localparam logic [3:0] PAT_BRIGHT    = 4'd15;

    // Register indexes
    localparam logic [1:0] REG_PATTERN = 2'd0;
    localparam logic [1:0] REG_TRANS   = 2'd1;
    localparam logic [1:0] REG_BRIGHT  = 2'd2;
    localparam logic [1:0] REG_PERIOD  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [9:0] len;
        logic [9:0] dv;   // fade divisor
    } t_seg;

    function automatic t_seg mk_seg(logic [1:0] kind, logic [7:0] value, logic [9:0] len);
        t_seg s;
        s.kind  = kind;
        s.value = value;
        s.len   = len;
        s.dv    = len + 10'd1;
        return s;
    endfunction

endpackage

// File: rtl/led_dim_pattern_level.sv
// Top level of the LED dim pattern level block: config registers and level pipeline.
//
//  channel  | direction | handshake           | payload
//  s_axis   | in        | tvalid/tready       | tdata[7:0] position
//  m_axis   | out       | tvalid/tready       | tdata[7:0] level, tuser[0] bad_setting
//  apb      | in        | psel/penable/pready | four registers at 0x0, 0x4, 0x8, 0xC
//
// One position per cycle unless stalled; stages: check, segment ends, segment
// pick and product, then four stages of a two-bit-per-stage restoring divider.
// The whole pipeline advances when the output register is empty or taken, so a
// stall holds every stage in place. Reset is synchronous and clears valid bits
// and the registers to pattern all-bright, period 255.
module led_dim_pattern_level (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] position
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] level
    output logic       m_axis_tuser,   // [0] bad_setting
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import ldpl_pkg::*;

    logic [3:0] r_pat;
    logic [6:0] r_trans;
    logic [7:0] r_bright;
    logic [7:0] r_period;
    logic [1:0] w_ridx;

    assign pready = 1'b1;
    assign w_ridx = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat    <= PAT_BRIGHT;
            r_trans  <= 7'd0;
            r_bright <= 8'd0;
            r_period <= 8'd255;
        end else if (psel && penable && pwrite) begin
            unique case (w_ridx)
                REG_PATTERN: r_pat    <= pwdata[3:0];
                REG_TRANS:   r_trans  <= pwdata[6:0];
                REG_BRIGHT:  r_bright <= pwdata[7:0];
                REG_PERIOD:  r_period <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (w_ridx)
            REG_PATTERN: prdata = {28'd0, r_pat};
            REG_TRANS:   prdata = {25'd0, r_trans};
            REG_BRIGHT:  prdata = {24'd0, r_bright};
            REG_PERIOD:  prdata = {24'd0, r_period};
            default:     prdata = 32'd0;
        endcase
    end

    logic w_adv;
    assign w_adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Stage 1: range check
    logic [9:0] w_total;
    logic       r1_vld, r1_err;
    logic [7:0] r1_pos;
    assign w_total = {2'd0, r_trans, 1'b0} + {2'd0, r_bright} + 10'd9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (w_adv) r1_vld <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_pos <= s_axis_tdata;
            r1_err <= (w_total > {2'd0, r_period}) || (s_axis_tdata >= r_period);
        end
    end

    // Stage 2: build segment list and running ends
    t_seg       w_seg [NSEG];
    logic [9:0] w_end [NSEG];
    logic [9:0] w_ps  [5][NSEG];
    logic [9:0] w_t, w_b, w_h, w_o, w_in, w_o2, w_in2;
    logic [7:0] w_lowval;

    assign w_t   = {3'd0, r_trans};
    assign w_b   = {2'd0, r_bright};
    assign w_h   = (w_b + 10'd9) >> 1;
    assign w_o   = (w_t + 10'd3) >> 1;
    assign w_in  = w_t + 10'd3 - w_o;
    assign w_o2  = (w_t + 10'd2) >> 1;
    assign w_in2 = w_t + 10'd2 - w_o2;
    assign w_lowval = (r_pat == PAT_STOW_HI || r_pat == PAT_SLIDE_HI) ? 8'd255 : 8'd32;

    always_comb begin
        for (int i = 0; i < NSEG; i++) w_seg[i] = mk_seg(SEG_CONST, 8'd0, 10'd0);
        unique case (r_pat)
            PAT_COMET: begin
                w_seg[0] = mk_seg(SEG_UP, 8'd0, (w_t << 1) + 10'd9);
                w_seg[1] = mk_seg(SEG_CONST, 8'd255, w_b);
            end
            PAT_RCOMET: begin
                w_seg[0] = mk_seg(SEG_CONST, 8'd255, w_b);
                w_seg[1] = mk_seg(SEG_DOWN, 8'd0, (w_t << 1) + 10'd9);
            end
            PAT_TWOSIDED: begin
                w_seg[0] = mk_seg(SEG_UP, 8'd0, w_t + 10'd4);
                w_seg[1] = mk_seg(SEG_CONST, 8'd255, w_b + 10'd1);
                w_seg[2] = mk_seg(SEG_DOWN, 8'd0, w_t + 10'd4);
            end
            PAT_BARBELL: begin
                w_seg[0] = mk_seg(SEG_CONST, 8'd255, w_t);
                w_seg[1] = mk_seg(SEG_DOWN, 8'd0, w_h);
                // middle pixel when b+9 is odd: one fade step over h+1
                w_seg[2] = mk_seg(SEG_UP, 8'd0, {9'd0, ~w_b[0]});
                w_seg[2].dv = w_h + 10'd1;
                w_seg[3] = mk_seg(SEG_UP, 8'd0, w_h);
                w_seg[4] = mk_seg(SEG_CONST, 8'd255, w_t);
            end
            PAT_STOW_HI, PAT_STOW_LO: begin
                w_seg[0] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[1] = mk_seg(SEG_DOWN, 8'd0, w_t + 10'd2);
                w_seg[2] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[3] = mk_seg(SEG_CONST, w_lowval, w_b + 10'd1);
                w_seg[4] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[5] = mk_seg(SEG_UP, 8'd0, w_t + 10'd2);
                w_seg[6] = mk_seg(SEG_CONST, 8'd255, 10'd1);
            end
            PAT_SLIDE_HI, PAT_SLIDE_LO: begin
                w_seg[0] = mk_seg(SEG_UP, 8'd0, w_t + 10'd2);
                w_seg[1] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[2] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[3] = mk_seg(SEG_CONST, w_lowval, w_b + 10'd1);
                w_seg[4] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[5] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[6] = mk_seg(SEG_DOWN, 8'd0, w_t + 10'd2);
            end
            PAT_BOWTIE: begin
                w_seg[0] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[1] = mk_seg(SEG_DOWN, 8'd0, w_o);
                w_seg[2] = mk_seg(SEG_UP, 8'd0, w_in);
                w_seg[3] = mk_seg(SEG_CONST, 8'd255, w_b + 10'd1);
                w_seg[4] = mk_seg(SEG_DOWN, 8'd0, w_in);
                w_seg[5] = mk_seg(SEG_UP, 8'd0, w_o);
                w_seg[6] = mk_seg(SEG_CONST, 8'd255, 10'd1);
            end
            PAT_RBOWTIE: begin
                w_seg[0] = mk_seg(SEG_UP, 8'd0, w_o2);
                w_seg[1] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[2] = mk_seg(SEG_DOWN, 8'd0, w_in2);
                w_seg[3] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[4] = mk_seg(SEG_CONST, 8'd255, w_b + 10'd1);
                w_seg[5] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[6] = mk_seg(SEG_UP, 8'd0, w_in2);
                w_seg[7] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[8] = mk_seg(SEG_DOWN, 8'd0, w_o2);
            end
            PAT_TOWERS, PAT_SNAKE3: begin
                w_seg[0] = mk_seg(SEG_CONST, (r_pat == PAT_TOWERS) ? 8'd32 : 8'd255,
                                  w_t + 10'd2);
                w_seg[1] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[2] = mk_seg(SEG_CONST, 8'd255, w_b + 10'd3);
                w_seg[3] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[4] = mk_seg(SEG_CONST, (r_pat == PAT_TOWERS) ? 8'd32 : 8'd255,
                                  w_t + 10'd2);
            end
            PAT_SNAKE: begin
                w_seg[0] = mk_seg(SEG_CONST, 8'd255, w_total);
            end
            PAT_COMETS3: begin
                w_seg[0] = mk_seg(SEG_UP, 8'd0, w_t + 10'd1);
                w_seg[1] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[2] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[3] = mk_seg(SEG_UP, 8'd0, w_b + 10'd2);
                w_seg[4] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[5] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[6] = mk_seg(SEG_UP, 8'd0, w_t + 10'd1);
                w_seg[7] = mk_seg(SEG_CONST, 8'd255, 10'd1);
            end
            PAT_RCOMETS3: begin
                w_seg[0] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[1] = mk_seg(SEG_DOWN, 8'd0, w_t + 10'd1);
                w_seg[2] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[3] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[4] = mk_seg(SEG_DOWN, 8'd0, w_b + 10'd2);
                w_seg[5] = mk_seg(SEG_CONST, 8'd0, 10'd1);
                w_seg[6] = mk_seg(SEG_CONST, 8'd255, 10'd1);
                w_seg[7] = mk_seg(SEG_DOWN, 8'd0, w_t + 10'd1);
            end
            default: begin
                w_seg[0] = mk_seg(SEG_CONST, 8'd255, {2'd0, r_period});
            end
        endcase
    end

    // Running ends as a log-depth prefix sum over the segment lengths
    always_comb begin
        for (int i = 0; i < NSEG; i++) w_ps[0][i] = w_seg[i].len;
        for (int l = 0; l < 4; l++) begin
            for (int i = 0; i < NSEG; i++) begin
                if (i >= (1 << l))
                    w_ps[l+1][i] = w_ps[l][i] + w_ps[l][(i >= (1 << l)) ? i - (1 << l) : 0];
                else
                    w_ps[l+1][i] = w_ps[l][i];
            end
        end
        for (int i = 0; i < NSEG; i++) w_end[i] = w_ps[4][i];
    end

    logic       r2_vld, r2_err;
    logic [7:0] r2_pos;
    t_seg       r2_seg [NSEG];
    logic [9:0] r2_end [NSEG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (w_adv) r2_vld <= r1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_pos <= r1_pos;
            r2_err <= r1_err;
            for (int i = 0; i < NSEG; i++) begin
                r2_seg[i] <= w_seg[i];
                r2_end[i] <= w_end[i];
            end
        end
    end

    // Stage 3: pick the segment holding the position and form 255*k, or a constant segment's value
    t_seg       w_pick;
    logic [9:0] w_start, w_off, w_k, w_dv;
    logic [17:0] w_num;
    logic       w_hit;

    always_comb begin
        w_pick  = mk_seg(SEG_CONST, 8'd0, 10'd0);
        w_start = 10'd0;
        w_hit   = 1'b0;
        // scan down so the first matching segment wins
        for (int i = NSEG - 1; i >= 0; i--) begin
            if ({2'd0, r2_pos} < r2_end[i]) begin
                w_pick  = r2_seg[i];
                w_start = (i == 0) ? 10'd0 : r2_end[(i == 0) ? 0 : i - 1];
                w_hit   = 1'b1;
            end
        end
        w_off = {2'd0, r2_pos} - w_start;
        unique case (w_pick.kind)
            SEG_UP:   w_k = w_off + 10'd1;
            SEG_DOWN: w_k = w_pick.len - w_off;
            default:  w_k = 10'd0;
        endcase
        if (r2_err || !w_hit) begin
            w_num = 18'd0;
            w_dv  = 10'd1;
        end else if (w_pick.kind == SEG_CONST) begin
            w_num = {10'd0, w_pick.value};
            w_dv  = 10'd1;
        end else begin
            w_num = {w_k, 8'd0} - {8'd0, w_k};
            w_dv  = w_pick.dv;
        end
    end

    logic        r3_vld, r3_err;
    logic [17:0] r3_num;
    logic [9:0]  r3_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (w_adv) r3_vld <= r2_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_err <= r2_err;
            r3_num <= w_num;
            r3_dv  <= w_dv;
        end
    end

    // Stages 4..7: restoring divide, two quotient bits per stage
    logic        r_dvld [4];
    logic        r_derr [4];
    logic [17:0] r_rem  [4];
    logic [9:0]  r_ddv  [4];
    logic [7:0]  r_q    [4];

    for (genvar g = 0; g < 4; g++) begin : g_div
        logic        w_ivld, w_ierr;
        logic [17:0] w_irem, w_r1, w_r2, w_d1, w_d2;
        logic [9:0]  w_idv;
        logic [7:0]  w_iq, w_q;

        if (g == 0) begin : g_first
            assign w_ivld = r3_vld;
            assign w_ierr = r3_err;
            assign w_irem = r3_num;
            assign w_idv  = r3_dv;
            assign w_iq   = 8'd0;
        end else begin : g_next
            assign w_ivld = r_dvld[g-1];
            assign w_ierr = r_derr[g-1];
            assign w_irem = r_rem[g-1];
            assign w_idv  = r_ddv[g-1];
            assign w_iq   = r_q[g-1];
        end

        assign w_d1 = {8'd0, w_idv} << (7 - 2 * g);
        assign w_d2 = {8'd0, w_idv} << (6 - 2 * g);

        always_comb begin
            w_q  = w_iq;
            w_r1 = w_irem;
            if (w_irem >= w_d1) begin
                w_r1 = w_irem - w_d1;
                w_q[7 - 2 * g] = 1'b1;
            end
            w_r2 = w_r1;
            if (w_r1 >= w_d2) begin
                w_r2 = w_r1 - w_d2;
                w_q[6 - 2 * g] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dvld[g] <= 1'b0;
            else if (w_adv) r_dvld[g] <= w_ivld;
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_derr[g] <= w_ierr;
                r_rem[g]  <= w_r2;
                r_ddv[g]  <= w_idv;
                r_q[g]    <= w_q;
            end
        end
    end

    assign m_axis_tvalid = r_dvld[3];
    assign m_axis_tdata  = r_q[3];
    assign m_axis_tuser  = r_derr[3];

endmodule
